// ===== hw/rtl/gfalu_pkg.sv =====
// Shared types, codes and helper functions of the binary field arithmetic unit.
`default_nettype none

package gfalu_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;
  localparam logic [1:0] OP_POW = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_MOD = 2'd1;
  localparam logic [1:0] ST_NO_INV   = 2'd2;

  // Multiplier operand A: the reduced constant one or the running base.
  typedef enum logic {A_ONE, A_BASE} a_sel_t;

  // Multiplier operand B sources.
  typedef enum logic [2:0] {B_OPA, B_OPB, B_ACC, B_BASE, B_T0} b_sel_t;

  // Result word sources.
  typedef enum logic [1:0] {RES_XOR, RES_PROD, RES_ACC, RES_ZERO} res_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    logic       wr_base;
    logic       wr_acc;
    logic       e_shift;
    logic       eu_init;
    logic       eu_step;
    logic       out_load;
    res_sel_t   res_sel;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       a_zero;
    logic       m_zero;
    logic       mul_busy;
    logic       mul_done;
    logic       e_zero;
    logic       e_lsb;
    logic       e_rest_zero;
    logic       r1_zero;
    logic       r0_one;
  } stat_t;

  // Degree of a polynomial word; zero for the zero word.
  function automatic logic [5:0] deg64(input logic [63:0] v);
    logic [5:0] d;
    d = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        d = 6'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gfalu_mulmod.sv =====
// Bit-serial modular multiplier: one bit of B per cycle, most significant first.
`default_nettype none

module gfalu_mulmod
  import gfalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] m,
  input  wire logic [5:0]  d,
  output logic [63:0]      prod,
  output logic             busy,
  output logic             done
);

  localparam logic [5:0] LAST_BIT = 6'd63;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [5:0]  cnt;
  logic [63:0] acc_next;

  // Horner step: multiply by x, fold back the top term, add A if the bit is set.
  always_comb begin
    acc_next = {prod[62:0], 1'b0};
    if (acc_next[d]) begin
      acc_next = acc_next ^ m;
    end
    if (b_r[63]) begin
      acc_next = acc_next ^ a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= LAST_BIT;
        prod <= '0;
        a_r  <= a;
        b_r  <= b;
      end else if (busy) begin
        prod <= acc_next;
        b_r  <= {b_r[62:0], 1'b0};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier finished without running");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/gfalu_datapath.sv =====
// Datapath: operand, modulus and Euclid registers, the shared multiplier and the result word.
`default_nettype none

module gfalu_datapath
  import gfalu_pkg::*;
#(
  parameter int MAX_DEGREE = 63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            st,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [62:0] in_a,
  input  wire logic [62:0] in_b,
  input  wire logic [63:0] in_e,
  input  wire logic [63:0] field_modulus,
  output logic [62:0]      result_value,
  output logic [1:0]       status
);

  localparam logic [62:0] OPND_MASK = 63'((64'd1 << MAX_DEGREE) - 64'd1);
  localparam logic [63:0] MOD_MASK  = 64'((65'd1 << (MAX_DEGREE + 1)) - 65'd1);

  logic [1:0]  op;
  logic [62:0] opa;
  logic [62:0] opb;
  logic [63:0] e;
  logic [63:0] m;
  logic [5:0]  d;
  logic [63:0] base;
  logic [63:0] acc;
  logic [63:0] r0, r1, t0, t1;
  logic [63:0] r0_next, r1_next, t0_next, t1_next;
  logic [63:0] mul_a, mul_b, prod;
  logic        mul_busy, mul_done;
  logic [5:0]  deg0, deg1, sh;

  always_comb begin
    mul_a = (cmd.a_sel == A_BASE) ? base : ((d == 6'd0) ? 64'd0 : 64'd1);
    case (cmd.b_sel)
      B_OPA:   mul_b = {1'b0, opa};
      B_OPB:   mul_b = {1'b0, opb};
      B_ACC:   mul_b = acc;
      B_BASE:  mul_b = base;
      B_T0:    mul_b = t0;
      default: mul_b = '0;
    endcase
  end

  gfalu_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m),
    .d     (d),
    .prod  (prod),
    .busy  (mul_busy),
    .done  (mul_done)
  );

  // One Euclid step: cancel the leading term of r0, or swap when r0 has fallen below r1.
  always_comb begin
    deg0    = deg64(r0);
    deg1    = deg64(r1);
    sh      = deg0 - deg1;
    r0_next = r1;
    r1_next = r0;
    t0_next = t1;
    t1_next = t0;
    if (r0 != 64'd0 && deg0 >= deg1) begin
      r0_next = r0 ^ (r1 << sh);
      t0_next = t0 ^ (t1 << sh);
      r1_next = r1;
      t1_next = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_opcode;
      opa <= in_a & OPND_MASK;
      opb <= in_b & OPND_MASK;
      e   <= in_e;
      m   <= field_modulus & MOD_MASK;
      d   <= deg64(field_modulus & MOD_MASK);
      acc <= 64'd1;
    end
    if (cmd.wr_base) begin
      base <= prod;
    end
    if (cmd.wr_acc) begin
      acc <= prod;
    end
    if (cmd.e_shift) begin
      e <= {1'b0, e[63:1]};
    end
    if (cmd.eu_init) begin
      r0 <= m;
      r1 <= base;
      t0 <= 64'd0;
      t1 <= 64'd1;
    end else if (cmd.eu_step) begin
      r0 <= r0_next;
      r1 <= r1_next;
      t0 <= t0_next;
      t1 <= t1_next;
    end
    if (cmd.out_load) begin
      status <= cmd.status;
      case (cmd.res_sel)
        RES_XOR:  result_value <= opa ^ opb;
        RES_PROD: result_value <= prod[62:0];
        RES_ACC:  result_value <= acc[62:0];
        default:  result_value <= '0;
      endcase
    end
  end

  always_comb begin
    st.op          = op;
    st.a_zero      = (opa == 63'd0);
    st.m_zero      = (m == 64'd0);
    st.mul_busy    = mul_busy;
    st.mul_done    = mul_done;
    st.e_zero      = (e == 64'd0);
    st.e_lsb       = e[0];
    st.e_rest_zero = (e[63:1] == 63'd0);
    st.r1_zero     = (r1 == 64'd0);
    st.r0_one      = (r0 == 64'd1);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gfalu_ctrl.sv =====
// Controller: sequences reduction, multiply, power and inverse, and owns the result valid flag.
`default_nettype none

module gfalu_ctrl
  import gfalu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_REDUCE, S_MUL_GO, S_MUL_WAIT, S_POW_CHECK, S_POW_ACC,
    S_POW_SHIFT, S_POW_SQ, S_INV_INIT, S_INV_STEP, S_INV_FIX, S_FINISH
  } state_t;

  state_t     state;
  res_sel_t   fin_sel;
  logic [1:0] fin_status;
  logic       out_free;
  logic       early_out;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign early_out = (st.op == OP_ADD) || (st.op == OP_INV && st.a_zero) || st.m_zero;

  always_comb begin
    cmd = '0;
    cmd.a_sel   = A_ONE;
    cmd.b_sel   = B_OPA;
    cmd.res_sel = fin_sel;
    cmd.status  = fin_status;
    case (state)
      S_IDLE:     cmd.load = in_valid;
      S_DISPATCH: cmd.mul_start = !early_out;
      S_REDUCE:   cmd.wr_base = st.mul_done;
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = A_BASE;
        cmd.b_sel     = B_OPB;
      end
      S_POW_CHECK: begin
        cmd.mul_start = !st.e_zero && st.e_lsb;
        cmd.a_sel     = A_BASE;
        cmd.b_sel     = B_ACC;
      end
      S_POW_ACC:  cmd.wr_acc = st.mul_done;
      S_POW_SHIFT: begin
        cmd.e_shift   = 1'b1;
        cmd.mul_start = !st.e_rest_zero;
        cmd.a_sel     = A_BASE;
        cmd.b_sel     = B_BASE;
      end
      S_POW_SQ:   cmd.wr_base = st.mul_done;
      S_INV_INIT: cmd.eu_init = 1'b1;
      S_INV_STEP: begin
        cmd.eu_step   = !st.r1_zero;
        cmd.mul_start = st.r1_zero && st.r0_one;
        cmd.b_sel     = B_T0;
      end
      S_FINISH:   cmd.out_load = out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (st.op == OP_ADD) begin
            fin_sel    <= RES_XOR;
            fin_status <= ST_OK;
            state      <= S_FINISH;
          end else if (st.op == OP_INV && st.a_zero) begin
            fin_sel    <= RES_ZERO;
            fin_status <= ST_NO_INV;
            state      <= S_FINISH;
          end else if (st.m_zero) begin
            fin_sel    <= RES_ZERO;
            fin_status <= ST_ZERO_MOD;
            state      <= S_FINISH;
          end else begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (st.mul_done) begin
            case (st.op)
              OP_MUL:  state <= S_MUL_GO;
              OP_POW:  state <= S_POW_CHECK;
              default: state <= S_INV_INIT;
            endcase
          end
        end
        S_MUL_GO:   state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (st.mul_done) begin
            fin_sel    <= RES_PROD;
            fin_status <= ST_OK;
            state      <= S_FINISH;
          end
        end
        S_POW_CHECK: begin
          if (st.e_zero) begin
            fin_sel    <= RES_ACC;
            fin_status <= ST_OK;
            state      <= S_FINISH;
          end else if (st.e_lsb) begin
            state <= S_POW_ACC;
          end else begin
            state <= S_POW_SHIFT;
          end
        end
        S_POW_ACC: begin
          if (st.mul_done) begin
            state <= S_POW_SHIFT;
          end
        end
        S_POW_SHIFT: state <= st.e_rest_zero ? S_POW_CHECK : S_POW_SQ;
        S_POW_SQ: begin
          if (st.mul_done) begin
            state <= S_POW_CHECK;
          end
        end
        S_INV_INIT: state <= S_INV_STEP;
        S_INV_STEP: begin
          if (st.r1_zero) begin
            if (st.r0_one) begin
              state <= S_INV_FIX;
            end else begin
              fin_sel    <= RES_ZERO;
              fin_status <= ST_NO_INV;
              state      <= S_FINISH;
            end
          end
        end
        S_INV_FIX: begin
          if (st.mul_done) begin
            fin_sel    <= RES_PROD;
            fin_status <= ST_OK;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gf2m_field_alu_unit.sv =====
// Top level of the GF(2^m) field arithmetic unit: stream ports, modulus register and wiring.
`default_nettype none

// Usage
// Words enter on the s_ stream group and leave on the m_ stream group, one result word for
// every input word. The opcode travels in s_tuser; the operands and the exponent in s_tdata.
// The field polynomial is held in a 64-bit register written through the APB-style port at
// byte address 0; it should be written only while the unit is idle.
//
// Throughput and cost: the unit works on one word at a time. Every modular multiplication
// runs through one shared bit-serial multiplier, and a pass consists of a start, 64 bit
// steps and a completion. Multiply costs two such passes (reduction of the first operand,
// then the product). Power costs one reduction plus up to two multiplications per exponent
// bit up to the highest set bit, so at most 128 passes for a 64-bit exponent. Inverse costs
// a reduction, one extended Euclid step per cycle (a cancellation or a swap, a few hundred
// at most) and a final reduction pass.
//
// Reset clears the controller and the valid flag and loads the modulus 0x11B. A new word is
// taken only when the controller is idle; a finished result waits in the output register
// while the receiver stalls, and a next word may already be accepted behind it, its result
// then waiting until the output register is free.

module gf2m_field_alu_unit
  import gfalu_pkg::*;
#(
  parameter int MAX_DEGREE = 63
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [191:0] s_tdata,  // operand_a[62:0], operand_b[125:63], exponent[189:126]
  input  wire logic [1:0]   s_tuser,  // opcode[1:0]
  // Output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,  // result_value[62:0], zero pad [63]
  output logic [1:0]        m_tuser,  // status[1:0]
  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam logic [63:0] MODULUS_RESET = 64'd283;

  logic [63:0] field_modulus;
  logic        cfg_write;
  cmd_t        cmd;
  stat_t       st;
  logic [62:0] result_value;
  logic [1:0]  status;

  // Only the register at index 0 exists; the register index is paddr[3].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? 64'd0 : field_modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_modulus <= MODULUS_RESET;
    end else if (cfg_write && !paddr[3]) begin
      field_modulus <= pwdata;
    end
  end

  gfalu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  gfalu_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_opcode     (s_tuser),
    .in_a          (s_tdata[62:0]),
    .in_b          (s_tdata[125:63]),
    .in_e          (s_tdata[189:126]),
    .field_modulus (field_modulus),
    .result_value  (result_value),
    .status        (status)
  );

  assign m_tdata = {1'b0, result_value};
  assign m_tuser = status;

  // An error status always carries a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |-> (result_value == 63'd0))
    else $error("error result carries a nonzero value");

  // One word at a time: after an accept the input side is closed in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

endmodule

`default_nettype wire
